@@ rtl/prng_printable_rotation_cipher_assert.svh @@
// Assertion macros shared by the cipher RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef PRNG_PRINTABLE_ROTATION_CIPHER_ASSERT_SVH
`define PRNG_PRINTABLE_ROTATION_CIPHER_ASSERT_SVH

// Same-cycle implication.
`define PRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/prc_pkg.sv @@
`timescale 1ns / 1ps

package prc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned GEN_W       = 17;
  localparam int unsigned PROD_W      = 24;
  localparam int unsigned KEY_W       = 7;
  localparam int unsigned REG_IDX_W   = 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [PROD_W-1:0] GEN_MULT   = 24'd75;
  localparam logic [GEN_W-1:0]  GEN_MOD    = 17'd65537;
  localparam logic [GEN_W-1:0]  GEN_RESET  = 17'd1;
  localparam logic [GEN_W-1:0]  SEED_RESET = 17'd1;
  localparam logic [BYTE_W-1:0] PRINT_BASE = 8'd32;
  localparam logic [KEY_W:0]    PRINT_SPAN = 8'd96;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_SEED   = 1'b0,
    REG_DECRYPT_MODE = 1'b1
  } cfg_reg_t;

  // One queued byte with the key its generator step produced.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [GEN_W-1:0]  key;
  } prc_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } prc_q_status_t;

  // g * 75 mod 65537: subtract the high half from the low half, wrap once.
  function automatic logic [GEN_W-1:0] advance_gen(input logic [GEN_W-1:0] g);
    logic [PROD_W-1:0] p;
    logic [15:0]       lo;
    logic [7:0]        hi;
    p  = {7'b0, g} * GEN_MULT;
    lo = p[15:0];
    hi = p[23:16];
    if (lo >= {8'b0, hi}) begin
      advance_gen = {1'b0, lo - {8'b0, hi}};
    end else begin
      advance_gen = {1'b0, lo} + GEN_MOD - {9'b0, hi};
    end
  endfunction

endpackage

@@ rtl/prc_front.sv @@
`timescale 1ns / 1ps

module prc_front import prc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  input  logic              in_tuser,
  input  logic [GEN_W-1:0]  start_seed,
  input  prc_q_status_t     q_status,
  output logic              push,
  output prc_item_t         push_item,
  output logic [GEN_W-1:0]  gen_value
);

  logic [GEN_W-1:0] gen_r;
  logic [GEN_W-1:0] gen_nxt;

  assign in_tready = !q_status.full;
  assign push      = in_tvalid && in_tready;

  // Restart reloads the seed before this byte's advance.
  assign gen_nxt   = advance_gen(in_tuser ? start_seed : gen_r);

  assign push_item.data_byte = in_tdata;
  assign push_item.key       = gen_nxt;
  assign gen_value           = gen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= GEN_RESET;
    end else if (push) begin
      gen_r <= gen_nxt;
    end
  end

endmodule

@@ rtl/prc_queue.sv @@
`timescale 1ns / 1ps

module prc_queue import prc_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  prc_item_t                  push_item,
  input  logic                       pop,
  output prc_item_t                  head_item,
  output prc_q_status_t              status,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int unsigned PTR_W = $clog2(Depth);
  localparam int unsigned CNT_W = $clog2(Depth + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Depth - 1);

  prc_item_t        mem [Depth];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head_item    = mem[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CNT_W'(Depth));
  assign count        = count_r;

endmodule

@@ rtl/prc_back.sv @@
`timescale 1ns / 1ps

module prc_back import prc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  prc_q_status_t     q_status,
  input  prc_item_t         head_item,
  input  logic              decrypt_mode,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata
);

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic [4:0]        dsum;
  logic [2:0]        fold1;
  logic [2:0]        fold2;
  logic [1:0]        rem3;
  logic [KEY_W-1:0]  k;
  logic [KEY_W-1:0]  pos;
  logic [KEY_W:0]    sum;
  logic [KEY_W:0]    wrapped;
  logic [BYTE_W-1:0] b;
  logic              printable;

  // key mod 96 = (key[16:5] mod 3) * 32 + key[4:0]; 4 == 1 mod 3, so sum 2-bit digits
  always_comb begin
    dsum = '0;
    for (int i = 0; i < 6; i++) begin
      dsum = dsum + {3'b0, head_item.key[5+2*i +: 2]};
    end
    fold1 = {1'b0, dsum[1:0]} + {1'b0, dsum[3:2]} + {2'b0, dsum[4]};
    fold2 = {1'b0, fold1[1:0]} + {2'b0, fold1[2]};
    rem3  = (fold2 >= 3'd3) ? 2'(fold2 - 3'd3) : fold2[1:0];
    k     = {rem3, head_item.key[4:0]};
  end

  always_comb begin
    b         = head_item.data_byte;
    printable = !b[7] && (b[6:5] != 2'b00);
    pos       = b[6:0] - PRINT_BASE[6:0];
    if (decrypt_mode) begin
      sum = {1'b0, pos} + (PRINT_SPAN - {1'b0, k});
    end else begin
      sum = {1'b0, pos} + {1'b0, k};
    end
    wrapped = (sum >= PRINT_SPAN) ? sum - PRINT_SPAN : sum;
  end

  assign pop = !q_status.empty && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = printable ? wrapped + PRINT_BASE : b;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/prng_printable_rotation_cipher.sv @@
// An accepted byte is queued, then rotated into the out_tdata register when that frees.
// Throughput: one byte per cycle while out_tready holds high; the generator update
//   (multiply by 75, fold mod 65537) is combinational; a two-entry queue feeds rotation.
// Reset (rst_n low at a rising edge, synchronous): generator and start_seed go to 1,
//   decrypt_mode to 0, queue and output register empty.
`timescale 1ns / 1ps

module prng_printable_rotation_cipher import prc_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BYTE_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                 in_tuser,   // [0] restart
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BYTE_W-1:0]    out_tdata,  // [7:0] out_byte
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [GEN_W-1:0]     cfg_wdata
);

  `include "prng_printable_rotation_cipher_assert.svh"

  localparam int unsigned CNT_W = $clog2(QueueDepth + 1);

  logic [GEN_W-1:0] seed_r;
  logic             decrypt_r;
  logic             push;
  logic             pop;
  prc_item_t        push_item;
  prc_item_t        head_item;
  prc_q_status_t    q_status;
  logic [CNT_W-1:0] q_count;
  logic [GEN_W-1:0] gen_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= SEED_RESET;
      decrypt_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_SEED:   seed_r    <= cfg_wdata;
        REG_DECRYPT_MODE: decrypt_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  prc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .start_seed (seed_r),
    .q_status   (q_status),
    .push       (push),
    .push_item  (push_item),
    .gen_value  (gen_value)
  );

  prc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status),
    .count     (q_count)
  );

  prc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_status     (q_status),
    .head_item    (head_item),
    .decrypt_mode (decrypt_r),
    .pop          (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

  `PRC_ASSERT_SAME(a_queue_bound, 1'b1, q_count <= CNT_W'(QueueDepth), "queue overfilled")
  `PRC_ASSERT_NEXT(a_restart_load, in_tvalid && in_tready && in_tuser,
                   gen_value == advance_gen($past(seed_r)), "restart did not reload seed")
  `PRC_ASSERT_NEXT(a_no_phantom, q_status.empty && !out_tvalid, !out_tvalid,
                   "output valid with nothing queued")

endmodule

@@ dv/prng_printable_rotation_cipher_test.sv @@
`timescale 1ns / 1ps

module prng_printable_rotation_cipher_test import prc_pkg::*;;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int NUM_ROWS    = 23;
  localparam int NUM_GROUPS  = 8;
  localparam int GROUP_BYTES = 50;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [GEN_W-1:0]  seed;
    logic              dec;
    logic [BYTE_W-1:0] data;
    logic              restart;
    logic              pinned;
    logic [BYTE_W-1:0] want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [BYTE_W-1:0]    out_tdata;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [GEN_W-1:0]     cfg_wdata;

  // Reference copy of the cipher state and its two registers.
  logic [GEN_W-1:0]  lehmer_g  = 17'd1;
  logic [GEN_W-1:0]  mode_seed = 17'd1;
  logic              mode_dec  = 1'b0;
  logic [BYTE_W-1:0] cipher_due[$];
  logic [BYTE_W-1:0] due_byte;

  // Directed rows may pin the expected byte instead of using the predictor.
  logic              pin_on   = 1'b0;
  logic [BYTE_W-1:0] pin_byte = '0;

  plan_row_t plan [0:NUM_ROWS-1];
  int        mismatches = 0;
  int        bytes_in   = 0;
  int        quiet      = 0;
  bit        calm       = 1'b0;
  bit        held_long  = 1'b0;

  prng_printable_rotation_cipher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte
    .in_tuser   (in_tuser),   // [0] restart
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_byte
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // g * 75 folded mod 65537 via low half minus high half.
  function automatic logic [GEN_W-1:0] next_lehmer(input logic [GEN_W-1:0] g);
    logic [31:0] prod;
    logic [31:0] lo;
    logic [31:0] hi;
    prod = 32'(g) * 32'd75;
    lo   = prod & 32'hFFFF;
    hi   = prod >> 16;
    if (lo >= hi) begin
      return GEN_W'(lo - hi);
    end else begin
      return GEN_W'(lo + 32'd65537 - hi);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] rotate_printable(input logic [BYTE_W-1:0] b,
                                                        input logic [GEN_W-1:0] key,
                                                        input logic back);
    int shift;
    int pos;
    if (b < 8'd32 || b > 8'd127) begin
      return b;
    end
    shift = int'(key) % 96;
    pos   = int'(b) - 32;
    if (back) begin
      pos = (pos + 96 - shift) % 96;
    end else begin
      pos = (pos + shift) % 96;
    end
    return BYTE_W'(pos + 32);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return BYTE_W'($urandom_range(32, 127));
      6: return BYTE_W'($urandom_range(0, 31));
      7: return BYTE_W'($urandom_range(128, 255));
      8: begin
        case ($urandom_range(0, 3))
          0: return 8'd31;
          1: return 8'd32;
          2: return 8'd127;
          default: return 8'd128;
        endcase
      end
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [GEN_W-1:0] pick_seed();
    case ($urandom_range(0, 6))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'd65535;
      3: return 17'd65536;
      4: return 17'd131071;
      5: return GEN_W'($urandom_range(1, 65536));
      default: return GEN_W'($urandom_range(0, 131071));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic r,
                           input logic pinned, input logic [BYTE_W-1:0] want);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= r;
    pin_on    <= pinned;
    pin_byte  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (cipher_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Drain first: registers change only while the cipher is idle.
  task automatic set_mode(input logic [GEN_W-1:0] seed, input logic dec);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_SEED;
    cfg_wdata <= seed;
    @(negedge clk);
    cfg_index <= REG_DECRYPT_MODE;
    cfg_wdata <= GEN_W'(dec);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (cipher_due.size() == 0) begin
          $error("out_byte: no transaction expected, got %0d", out_tdata);
          mismatches++;
        end else begin
          due_byte = cipher_due.pop_front();
          if (out_tdata !== due_byte) begin
            $error("out_byte: expected %0d, got %0d", due_byte, out_tdata);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          lehmer_g = mode_seed;
        end
        lehmer_g = next_lehmer(lehmer_g);
        cipher_due.push_back(pin_on ? pin_byte
                                    : rotate_printable(in_tdata, lehmer_g, mode_dec));
        bytes_in++;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_SEED:   mode_seed = cfg_wdata;
          REG_DECRYPT_MODE: mode_dec  = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back up the input side.
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!held_long && bytes_in >= 150) begin
        held_long = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_START_SEED;
    cfg_wdata = '0;

    // Reset values first, then zero seed, top of range, above range, one below top.
    plan = '{
      '{ROW_BYTE, 17'd0,      1'b0, 8'd32,  1'b0, 1'b1, 8'd107},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd0,   1'b0, 1'b1, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd255, 1'b0, 1'b1, 8'd255},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd31,  1'b0, 1'b1, 8'd31},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd128, 1'b0, 1'b1, 8'd128},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd127, 1'b1, 1'b0, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd96,  1'b0, 1'b0, 8'd0},
      '{ROW_CFG,  17'd0,      1'b0, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd127, 1'b1, 1'b1, 8'd127},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd32,  1'b0, 1'b1, 8'd32},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd77,  1'b0, 1'b1, 8'd77},
      '{ROW_CFG,  17'd65536,  1'b1, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd32,  1'b1, 1'b0, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd127, 1'b0, 1'b0, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd200, 1'b0, 1'b1, 8'd200},
      '{ROW_CFG,  17'd131071, 1'b1, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd64,  1'b1, 1'b0, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd33,  1'b0, 1'b0, 8'd0},
      '{ROW_CFG,  17'd65535,  1'b0, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd126, 1'b1, 1'b0, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd1,   1'b0, 1'b1, 8'd1},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd95,  1'b0, 1'b0, 8'd0},
      '{ROW_BYTE, 17'd0,      1'b0, 8'd127, 1'b0, 1'b0, 8'd0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        set_mode(plan[i].seed, plan[i].dec);
      end else begin
        push_byte(plan[i].data, plan[i].restart, plan[i].pinned, plan[i].want);
      end
    end

    // Mostly continuing streams with an occasional restart; quiet last group.
    for (int grp = 0; grp < NUM_GROUPS; grp++) begin
      set_mode(pick_seed(), 1'($urandom_range(0, 1)));
      calm = (grp == NUM_GROUPS - 1);
      repeat (GROUP_BYTES) begin
        push_byte(pick_byte(), ($urandom_range(0, 19) == 0), 1'b0, 8'd0);
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && cipher_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/prc_pkg.sv
rtl/prc_front.sv
rtl/prc_queue.sv
rtl/prc_back.sv
rtl/prng_printable_rotation_cipher.sv
dv/prng_printable_rotation_cipher_test.sv
